/* design/swec_pkg.sv */
package swec_pkg;

  localparam int MaxBuckets = 64;
  localparam int SlotW      = $clog2(MaxBuckets);
  localparam int OccW       = $clog2(MaxBuckets + 1);

  localparam logic [0:0] CfgBucketSeconds = 1'b0;
  localparam logic [0:0] CfgWindowBuckets = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StDiv,
    StSpan,
    StRdNew,
    StCmpNew,
    StDrop,
    StAppend,
    StRdOld,
    StCmpOld,
    StOut
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture item, start rounding
    logic div_step;   // one remainder bit
    logic span_mul;   // compute base and span
    logic rd_newest;  // read newest entry
    logic inc_newest; // bump newest count
    logic drop;       // drop oldest (count must be read)
    logic append;     // open new bucket
    logic rd_oldest;  // read oldest entry
    logic count_evt;  // bump total
    logic out_load;   // load result register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic is_event;
    logic empty;
    logic full;
    logic newest_match;
    logic oldest_expired;
  } dp_sts_t;

endpackage

/* design/swec_stream_if.sv */
interface swec_stream_if #(
  parameter int Width = 32
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* design/swec_cfg_if.sv */
interface swec_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] wdata;
  modport source(output valid, output index, output wdata, input ready);
  modport sink(input valid, input index, input wdata, output ready);
endinterface

/* design/sliding_window_event_counter.sv */
// Sliding-window event counter over time buckets.
// Channels: in_if (sink) carries data = {mode, timestamp[31:0]}; mode 0
// records one event, mode 1 only queries. out_if (source) carries the
// window_count for each item, exactly one result per item, in order.
// cfg_if writes bucket_seconds (index 0) and window_buckets (index 1);
// it is always ready and may only be used while the block is idle.
// An item's work: the 32-step bit-serial remainder for the timestamp rounding
// sets the bulk; an event adds its bucket update, from an append on an empty
// ring to an eviction on a full one; the expiry walk over the single-port ring
// memory sets the rest, growing with each expired bucket.
// One item is in work at a time; the next item is accepted in the cycle after
// the result is loaded. The result sits in an output register, so the next
// item is taken while that result still waits.
// Reset: ring empty, total zero, bucket_seconds 1, window_buckets 60.
// The ring memory itself is not cleared; only live entries are read.
// A stalled receiver holds the result; a following item completes its
// work and then waits until the output register is free.
module sliding_window_event_counter (
  input logic      clk_i,
  input logic      rst_ni,
  swec_stream_if.sink   in_if,
  swec_stream_if.source out_if,
  swec_cfg_if.sink      cfg_if
);

  swec_pkg::dp_cmd_t cmd;
  swec_pkg::dp_sts_t sts;
  logic [15:0] bucket_seconds_q;
  logic [6:0]  window_buckets_q;
  logic        out_valid_q;

  assign cfg_if.ready = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_seconds_q <= 16'd1;
      window_buckets_q <= 7'd60;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        swec_pkg::CfgBucketSeconds: bucket_seconds_q <= cfg_if.wdata;
        swec_pkg::CfgWindowBuckets: window_buckets_q <= cfg_if.wdata[6:0];
        default: ;
      endcase
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_if.valid = out_valid_q;

  swec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_busy_i (out_valid_q & ~out_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  swec_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mode_i        (in_if.data[32]),
    .in_timestamp_i   (in_if.data[31:0]),
    .bucket_seconds_i (bucket_seconds_q),
    .window_buckets_i (window_buckets_q),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .result_o         (out_if.data)
  );

endmodule

/* design/swec_ctrl.sv */
module swec_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_busy_i,
  input  swec_pkg::dp_sts_t sts_i,
  output swec_pkg::dp_cmd_t cmd_o
);

  swec_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swec_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      swec_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = swec_pkg::StDiv;
        end
      end
      swec_pkg::StDiv: begin
        // step until the done flag shows, then stop stepping
        if (sts_i.div_done) state_d = swec_pkg::StSpan;
        else cmd_o.div_step = 1'b1;
      end
      swec_pkg::StSpan: begin
        cmd_o.span_mul = 1'b1;
        if (!sts_i.is_event) state_d = swec_pkg::StRdOld;
        else if (sts_i.empty) state_d = swec_pkg::StAppend;
        else state_d = swec_pkg::StRdNew;
      end
      swec_pkg::StRdNew: begin
        cmd_o.rd_newest = 1'b1;
        state_d         = swec_pkg::StCmpNew;
      end
      swec_pkg::StCmpNew: begin
        if (sts_i.newest_match) begin
          cmd_o.inc_newest = 1'b1;
          cmd_o.count_evt  = 1'b1;
          state_d          = swec_pkg::StRdOld;
        end else if (sts_i.full) begin
          cmd_o.rd_oldest = 1'b1;
          state_d         = swec_pkg::StDrop;
        end else begin
          state_d = swec_pkg::StAppend;
        end
      end
      swec_pkg::StDrop: begin
        cmd_o.drop = 1'b1;
        state_d    = swec_pkg::StAppend;
      end
      swec_pkg::StAppend: begin
        cmd_o.append    = 1'b1;
        cmd_o.count_evt = 1'b1;
        state_d         = swec_pkg::StRdOld;
      end
      swec_pkg::StRdOld: begin
        if (sts_i.empty) begin
          state_d = swec_pkg::StOut;
        end else begin
          cmd_o.rd_oldest = 1'b1;
          state_d         = swec_pkg::StCmpOld;
        end
      end
      swec_pkg::StCmpOld: begin
        if (sts_i.oldest_expired) begin
          cmd_o.drop = 1'b1;
          state_d    = swec_pkg::StRdOld;
        end else begin
          state_d = swec_pkg::StOut;
        end
      end
      swec_pkg::StOut: begin
        if (!out_busy_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = swec_pkg::StIdle;
        end
      end
      default: state_d = swec_pkg::StIdle;
    endcase
  end

endmodule

/* design/swec_dp.sv */
module swec_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_mode_i,
  input  logic [31:0]       in_timestamp_i,
  input  logic [15:0]       bucket_seconds_i,
  input  logic [6:0]        window_buckets_i,
  input  swec_pkg::dp_cmd_t cmd_i,
  output swec_pkg::dp_sts_t sts_o,
  output logic [31:0]       result_o
);

  localparam int SlotW = swec_pkg::SlotW;
  localparam int OccW  = swec_pkg::OccW;

  logic [31:0] bucket_time_mem  [swec_pkg::MaxBuckets];
  logic [31:0] bucket_count_mem [swec_pkg::MaxBuckets];

  logic             mode_q;
  logic [31:0]      ts_q;
  logic [15:0]      len_q;
  logic [16:0]      rem_q;
  logic [5:0]       bit_q;
  logic             div_done_q;
  logic [31:0]      base_q;
  logic [38:0]      span_q;
  logic [SlotW-1:0] oldest_q;
  logic [OccW-1:0]  occ_q;
  logic [31:0]      total_q;
  logic [31:0]      rd_time_q, rd_count_q;

  logic [SlotW-1:0] newest_slot, tail_slot, rd_addr;
  logic [16:0]      rem_sh;
  logic [15:0]      len_eff;

  assign len_eff     = (bucket_seconds_i == '0) ? 16'd1 : bucket_seconds_i;
  assign tail_slot   = oldest_q + occ_q[SlotW-1:0];
  assign newest_slot = tail_slot - SlotW'(1);
  assign rd_addr     = cmd_i.rd_newest ? newest_slot : oldest_q;
  assign rem_sh      = {rem_q[15:0], ts_q[bit_q[4:0]]};

  // ring memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      bucket_time_mem[tail_slot]  <= base_q;
      bucket_count_mem[tail_slot] <= 32'd1;
    end else if (cmd_i.inc_newest && rd_count_q != '1) begin
      bucket_count_mem[newest_slot] <= rd_count_q + 32'd1;
    end
    if (cmd_i.rd_newest || cmd_i.rd_oldest) begin
      rd_time_q  <= bucket_time_mem[rd_addr];
      rd_count_q <= bucket_count_mem[rd_addr];
    end
  end

  // item capture, restoring remainder, base and span
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= in_mode_i;
      ts_q   <= in_timestamp_i;
      len_q  <= len_eff;
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= (rem_sh >= {1'b0, len_q}) ? rem_sh - {1'b0, len_q} : rem_sh;
    end
    if (cmd_i.span_mul) begin
      base_q <= ts_q - {16'd0, rem_q[15:0]};
      span_q <= 39'({7'd0, len_q} * {16'd0, window_buckets_i});
    end
  end

  // bit counter for the remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q      <= '0;
      div_done_q <= 1'b0;
    end else if (cmd_i.load) begin
      bit_q      <= 6'd31;
      div_done_q <= 1'b0;
    end else if (cmd_i.div_step) begin
      bit_q      <= bit_q - 6'd1;
      div_done_q <= (bit_q == 6'd0);
    end
  end

  // ring pointers, total and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      occ_q    <= '0;
      total_q  <= '0;
      result_o <= '0;
    end else begin
      if (cmd_i.drop) begin
        oldest_q <= oldest_q + SlotW'(1);
        total_q  <= (total_q >= rd_count_q) ? total_q - rd_count_q : '0;
      end else if (cmd_i.count_evt && total_q != '1) begin
        total_q <= total_q + 32'd1;
      end
      if (cmd_i.append) occ_q <= occ_q + OccW'(1);
      else if (cmd_i.drop) occ_q <= occ_q - OccW'(1);
      if (cmd_i.out_load) result_o <= total_q;
    end
  end

  assign sts_o.div_done       = div_done_q;
  assign sts_o.is_event       = ~mode_q;
  assign sts_o.empty          = (occ_q == '0);
  assign sts_o.full           = (occ_q == OccW'(swec_pkg::MaxBuckets));
  assign sts_o.newest_match   = (rd_time_q == base_q);
  assign sts_o.oldest_expired = ({7'd0, rd_time_q} + span_q) <= {7'd0, base_q};

endmodule
